@@ rtl/record_byte_ring_buffer_defines.svh @@
// assertion macros for the record byte ring buffer
`ifndef RECORD_BYTE_RING_BUFFER_DEFINES_SVH
`define RECORD_BYTE_RING_BUFFER_DEFINES_SVH

// same-cycle implication, held off during reset
`define RBRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define RBRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rbrb_pkg.sv @@
// shared types and constants for the record byte ring buffer
`timescale 1ns / 1ps
`default_nettype none

package rbrb_pkg;

    localparam int unsigned MAX_DEPTH = 1024;
    localparam int unsigned ADDR_W = $clog2(MAX_DEPTH);
    localparam int unsigned CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int unsigned OFFS_W = 10;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DROP_W = 32;
    localparam int unsigned OP_W = 2;

    // offset remainder pipeline: restoring steps per stage
    localparam int unsigned STEPS_PER_STAGE = 2;
    localparam int unsigned MOD_STAGES = (OFFS_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int unsigned SUB_W = OFFS_W + CNT_W;

    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(MAX_DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_PEEK    = 2'd1,
        OP_CONSUME = 2'd2,
        OP_TAKE    = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              first;
        logic [CNT_W-1:0]  amount;
        logic [BYTE_W-1:0] data_byte;
        logic [OFFS_W-1:0] offs;
    } item_t;

    typedef struct packed {
        logic              accepted;
        logic [CNT_W-1:0]  contig;
        logic [ADDR_W-1:0] read_pos;
        logic [DROP_W-1:0] dropped;
        logic [CNT_W-1:0]  used;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/rbrb_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module rbrb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/rbrb_modpipe.sv @@
// input register and pipelined peek offset remainder against capacity
`timescale 1ns / 1ps
`default_nettype none

module rbrb_modpipe (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [rbrb_pkg::CNT_W-1:0]   cap,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire rbrb_pkg::item_t              in_item,
    output logic                              item_valid,
    input  wire logic                         item_ready,
    output rbrb_pkg::item_t                   item
);

    import rbrb_pkg::*;

    logic [MOD_STAGES:0] valid_reg;
    item_t               item_reg [0:MOD_STAGES];
    item_t               item_next [1:MOD_STAGES];
    logic [MOD_STAGES:0] stage_rdy;

    // STEPS_PER_STAGE restoring remainder steps, shifts taken from the stage number
    function automatic logic [OFFS_W-1:0] stage_rem(
        input logic [OFFS_W-1:0] rem_in,
        input logic [CNT_W-1:0]  cap_in,
        input int unsigned       stage
    );
        logic [SUB_W-1:0] rem_w;
        logic [SUB_W-1:0] div_w;
        int unsigned      step;
        rem_w = SUB_W'(rem_in);
        div_w = '0;
        step  = 0;
        for (int unsigned s = 0; s < STEPS_PER_STAGE; s++)
        begin
            step = stage * STEPS_PER_STAGE + s;
            if (step < OFFS_W)
            begin
                div_w = SUB_W'(cap_in) << (OFFS_W - 1 - step);
                if (rem_w >= div_w)
                begin
                    rem_w = rem_w - div_w;
                end
            end
        end
        return rem_w[OFFS_W-1:0];
    endfunction

    always_comb
    begin
        stage_rdy[MOD_STAGES] = !valid_reg[MOD_STAGES] || item_ready;
        for (int k = MOD_STAGES - 1; k >= 0; k--)
        begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k+1];
        end
    end

    always_comb
    begin
        for (int unsigned k = 1; k <= MOD_STAGES; k++)
        begin
            item_next[k]      = item_reg[k-1];
            item_next[k].offs = stage_rem(item_reg[k-1].offs, cap, k - 1);
        end
    end

    assign in_ready   = stage_rdy[0];
    assign item_valid = valid_reg[MOD_STAGES];
    assign item       = item_reg[MOD_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_rdy[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int unsigned k = 1; k <= MOD_STAGES; k++)
            begin
                if (stage_rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[0] && in_valid)
        begin
            item_reg[0] <= in_item;
        end
        for (int unsigned k = 1; k <= MOD_STAGES; k++)
        begin
            if (stage_rdy[k] && valid_reg[k-1])
            begin
                item_reg[k] <= item_next[k];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/rbrb_core.sv @@
// pointer state, ring storage and result register
`timescale 1ns / 1ps
`default_nettype none

module rbrb_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [rbrb_pkg::CNT_W-1:0]    cfg_wr_data,
    output logic      [rbrb_pkg::CNT_W-1:0]    cap,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire rbrb_pkg::item_t               item,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output rbrb_pkg::result_t                  res,
    output logic      [rbrb_pkg::BYTE_W-1:0]   res_byte
);

    import rbrb_pkg::*;

    logic [CNT_W-1:0]  cap_reg;
    logic [ADDR_W-1:0] wr_idx_reg, wr_idx_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  pend_reg, pend_next;
    logic [DROP_W-1:0] drop_reg, drop_next;
    logic [DROP_W-1:0] drop_mid;
    logic              res_valid_reg;
    result_t           res_reg, res_next;
    logic              peek_reg, peek_next;

    logic              load;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_q;
    logic [CNT_W-1:0]  held_cur;
    logic [CNT_W-1:0]  held_new;
    logic [CNT_W-1:0]  consume_amt;
    logic [CNT_W-1:0]  gap;

    function automatic logic [ADDR_W-1:0] wrap_add(
        input logic [ADDR_W-1:0] idx,
        input logic [CNT_W-1:0]  n,
        input logic [CNT_W-1:0]  cap_in
    );
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(idx) + (CNT_W + 1)'(n);
        if (sum >= (CNT_W + 1)'(cap_in))
        begin
            sum = sum - (CNT_W + 1)'(cap_in);
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign cap        = (cap_reg > CAP_MAX) ? CAP_MAX : cap_reg;
    assign item_ready = !res_valid_reg || res_ready;
    assign load       = item_valid && item_ready;
    assign held_cur   = fill_reg - pend_reg;
    assign ram_raddr  = wrap_add(rd_idx_reg, CNT_W'(item.offs), cap);

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        fill_next   = fill_reg;
        pend_next   = pend_reg;
        drop_mid    = drop_reg;
        ram_we      = 1'b0;
        peek_next   = 1'b0;
        consume_amt = (item.amount > held_cur) ? held_cur : item.amount;
        res_next    = '0;
        case (item.op)
            OP_ENQUEUE:
            begin
                if (item.first)
                begin
                    // a cut-short record leaves its missing bytes behind the write index
                    if (pend_reg != '0 && cap != '0)
                    begin
                        wr_idx_next = wrap_add(wr_idx_reg, pend_reg, cap);
                    end
                    pend_next = '0;
                    if (cap == '0 || item.amount == '0 || item.amount > cap - fill_reg)
                    begin
                        drop_mid = drop_reg + DROP_W'(1);
                    end
                    else
                    begin
                        fill_next         = fill_reg + item.amount;
                        pend_next         = item.amount;
                        res_next.accepted = 1'b1;
                    end
                end
                else if (pend_reg != '0 && cap != '0)
                begin
                    ram_we            = 1'b1;
                    wr_idx_next       = wrap_add(wr_idx_reg, CNT_W'(1), cap);
                    pend_next         = pend_reg - CNT_W'(1);
                    res_next.accepted = 1'b1;
                end
            end
            OP_PEEK:
            begin
                peek_next = (cap != '0);
            end
            OP_CONSUME:
            begin
                if (cap != '0)
                begin
                    rd_idx_next = wrap_add(rd_idx_reg, consume_amt, cap);
                    fill_next   = fill_reg - consume_amt;
                end
            end
            OP_TAKE:
            begin
            end
            default:
            begin
            end
        endcase

        drop_next = (item.op == OP_TAKE) ? '0 : drop_mid;

        held_new = fill_next - pend_next;
        gap      = (cap > CNT_W'(rd_idx_next)) ? cap - CNT_W'(rd_idx_next) : '0;

        res_next.contig   = (held_new < gap) ? held_new : gap;
        res_next.read_pos = rd_idx_next;
        res_next.dropped  = drop_mid;
        res_next.used     = held_new;
    end

    rbrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (load && ram_we),
        .wr_addr (wr_idx_reg),
        .wr_data (item.data_byte),
        .rd_en   (load && peek_next),
        .rd_addr (ram_raddr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_MAX;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            fill_reg      <= '0;
            pend_reg      <= '0;
            drop_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg    <= cfg_wr_data;
                wr_idx_reg <= '0;
                rd_idx_reg <= '0;
                fill_reg   <= '0;
                pend_reg   <= '0;
                drop_reg   <= '0;
            end
            else if (load)
            begin
                wr_idx_reg <= wr_idx_next;
                rd_idx_reg <= rd_idx_next;
                fill_reg   <= fill_next;
                pend_reg   <= pend_next;
                drop_reg   <= drop_next;
            end
            if (item_ready)
            begin
                res_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= res_next;
            peek_reg <= peek_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign res_byte  = peek_reg ? ram_q : '0;

endmodule

`default_nettype wire

@@ rtl/record_byte_ring_buffer.sv @@
// top level of the record byte ring buffer
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    operation first_of_record amount data_byte
//                                              peek_offset
//  out       source     out_valid / out_ready  accepted contiguous_length read_position
//                                              read_byte dropped_count used_bytes
//  cfg       sink       cfg_wr_en              cfg_wr_data (capacity)
//
//  one request per cycle unless out_ready stalls; a request passes the input register,
//  five stages of two steps for the peek remainder against capacity, and result register
//  asynchronous reset clears pointers, counters and valids; storage is not cleared
//  a stalled output fills the internal stages before in_ready drops
`timescale 1ns / 1ps
`default_nettype none
`include "record_byte_ring_buffer_defines.svh"

module record_byte_ring_buffer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [rbrb_pkg::CNT_W-1:0]    cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [rbrb_pkg::OP_W-1:0]     operation,
    input  wire logic                          first_of_record,
    input  wire logic [rbrb_pkg::CNT_W-1:0]    amount,
    input  wire logic [rbrb_pkg::BYTE_W-1:0]   data_byte,
    input  wire logic [rbrb_pkg::OFFS_W-1:0]   peek_offset,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               accepted,
    output logic      [rbrb_pkg::CNT_W-1:0]    contiguous_length,
    output logic      [rbrb_pkg::ADDR_W-1:0]   read_position,
    output logic      [rbrb_pkg::BYTE_W-1:0]   read_byte,
    output logic      [rbrb_pkg::DROP_W-1:0]   dropped_count,
    output logic      [rbrb_pkg::CNT_W-1:0]    used_bytes
);

    import rbrb_pkg::*;

    item_t            in_item;
    item_t            item;
    logic             item_valid;
    logic             item_ready;
    logic [CNT_W-1:0] cap;
    result_t          res;

    always_comb
    begin
        in_item.op        = op_t'(operation);
        in_item.first     = first_of_record;
        in_item.amount    = amount;
        in_item.data_byte = data_byte;
        in_item.offs      = peek_offset;
    end

    rbrb_modpipe u_modpipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .cap        (cap),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    rbrb_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cap         (cap),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .res_valid   (out_valid),
        .res_ready   (out_ready),
        .res         (res),
        .res_byte    (read_byte)
    );

    assign accepted          = res.accepted;
    assign contiguous_length = res.contig;
    assign read_position     = res.read_pos;
    assign dropped_count     = res.dropped;
    assign used_bytes        = res.used;

    // contiguous run never exceeds held bytes
    `RBRB_ASSERT_NOW(a_contig_le_used, clk, rst_n, out_valid,
        contiguous_length <= used_bytes, "contiguous run exceeds held bytes")

    // held bytes never exceed capacity
    `RBRB_ASSERT_NOW(a_used_le_cap, clk, rst_n, out_valid && !cfg_wr_en,
        used_bytes <= cap, "held bytes exceed capacity")

    // read position stays inside storage in use
    `RBRB_ASSERT_NOW(a_rdpos_in_cap, clk, rst_n, out_valid && !cfg_wr_en,
        (CNT_W'(read_position) < cap) || (cap == '0), "read position outside capacity")

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// testbench for the record byte ring buffer: directed and random requests against a predictor
`timescale 1ns / 1ps

module testbench;

    import rbrb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;

    typedef struct packed {
        logic              accepted;
        logic [CNT_W-1:0]  contig;
        logic [ADDR_W-1:0] read_pos;
        logic [BYTE_W-1:0] rbyte;
        logic [DROP_W-1:0] dropped;
        logic [CNT_W-1:0]  used;
    } ring_status_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]  cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [OP_W-1:0]   operation = OP_ENQUEUE;
    logic              first_of_record = 1'b0;
    logic [CNT_W-1:0]  amount = '0;
    logic [BYTE_W-1:0] data_byte = '0;
    logic [OFFS_W-1:0] peek_offset = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              accepted;
    logic [CNT_W-1:0]  contiguous_length;
    logic [ADDR_W-1:0] read_position;
    logic [BYTE_W-1:0] read_byte;
    logic [DROP_W-1:0] dropped_count;
    logic [CNT_W-1:0]  used_bytes;

    // predictor state
    logic [BYTE_W-1:0] shadow_bytes [MAX_DEPTH];
    bit                shadow_written [MAX_DEPTH];
    int                capacity_reg = int'(MAX_DEPTH);
    int                wr_ptr;
    int                rd_ptr;
    int                reserved;
    int                awaiting;
    logic [DROP_W-1:0] drop_tally;

    ring_status_t ring_status_q [$];

    int send_gap_pct = 9;
    int recv_stall_pct = 55;
    int failures;
    int requests_sent;
    int results_checked;
    int records_admitted;
    int records_dropped;
    int capacity_writes;

    record_byte_ring_buffer i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .operation         (operation),
        .first_of_record   (first_of_record),
        .amount            (amount),
        .data_byte         (data_byte),
        .peek_offset       (peek_offset),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .accepted          (accepted),
        .contiguous_length (contiguous_length),
        .read_position     (read_position),
        .read_byte         (read_byte),
        .dropped_count     (dropped_count),
        .used_bytes        (used_bytes)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int eff_capacity();
        return (capacity_reg > int'(MAX_DEPTH)) ? int'(MAX_DEPTH) : capacity_reg;
    endfunction

    function automatic int ring_wrap(int idx, int cap);
        return (idx >= cap) ? idx - cap : idx;
    endfunction

    task automatic predict_ring_status(op_t op, logic first, int amt, int data, int offs);
        ring_status_t st;
        int cap;
        int held;
        int gap;
        st = '0;
        cap = eff_capacity();
        case (op)
            OP_ENQUEUE:
            begin
                if (first)
                begin
                    if (awaiting != 0 && cap != 0)
                        wr_ptr = ring_wrap(wr_ptr + awaiting, cap);
                    awaiting = 0;
                    if (cap == 0 || amt == 0 || amt > cap - reserved)
                    begin
                        drop_tally = drop_tally + DROP_W'(1);
                        records_dropped++;
                    end
                    else
                    begin
                        reserved += amt;
                        awaiting = amt;
                        st.accepted = 1'b1;
                        records_admitted++;
                    end
                end
                else if (awaiting != 0 && cap != 0)
                begin
                    shadow_bytes[wr_ptr] = data[7:0];
                    shadow_written[wr_ptr] = 1'b1;
                    wr_ptr = ring_wrap(wr_ptr + 1, cap);
                    awaiting--;
                    st.accepted = 1'b1;
                end
            end
            OP_PEEK:
            begin
                if (cap != 0)
                    st.rbyte = shadow_bytes[(rd_ptr + offs) % cap];
            end
            OP_CONSUME:
            begin
                if (cap != 0)
                begin
                    held = reserved - awaiting;
                    if (amt > held)
                        amt = held;
                    rd_ptr = ring_wrap(rd_ptr + amt, cap);
                    reserved -= amt;
                end
            end
            default:
            begin
            end
        endcase
        st.dropped = drop_tally;
        if (op == OP_TAKE)
            drop_tally = '0;
        held = reserved - awaiting;
        gap = (cap > rd_ptr) ? cap - rd_ptr : 0;
        st.contig = CNT_W'((held < gap) ? held : gap);
        st.read_pos = ADDR_W'(rd_ptr);
        st.used = CNT_W'(held);
        ring_status_q.push_back(st);
    endtask

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endtask

    task automatic check_ring_status();
        ring_status_t want;
        if (ring_status_q.size() == 0)
        begin
            $error("result with no request outstanding");
            failures++;
        end
        else
        begin
            want = ring_status_q.pop_front();
            compare_field("accepted", 32'(want.accepted), 32'(accepted));
            compare_field("contiguous_length", 32'(want.contig), 32'(contiguous_length));
            compare_field("read_position", 32'(want.read_pos), 32'(read_position));
            compare_field("read_byte", 32'(want.rbyte), 32'(read_byte));
            compare_field("dropped_count", want.dropped, dropped_count);
            compare_field("used_bytes", 32'(want.used), 32'(used_bytes));
            results_checked++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_ring_status();
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $error("no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic send_request(op_t op, logic first, logic [CNT_W-1:0] amt,
            logic [BYTE_W-1:0] data, logic [OFFS_W-1:0] offs);
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        operation       <= op;
        first_of_record <= first;
        amount          <= amt;
        data_byte       <= data;
        peek_offset     <= offs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_ring_status(op, first, int'(amt), int'(data), int'(offs));
        requests_sent++;
    endtask

    // peek at written storage, or anywhere at zero capacity; take when nothing is written
    task automatic send_peek();
        int cap;
        int start;
        int idx;
        int offs;
        bit found;
        cap = eff_capacity();
        found = 1'b0;
        idx = 0;
        offs = $urandom_range(0, 1023);
        if (cap != 0)
        begin
            start = $urandom_range(0, cap - 1);
            for (int k = 0; k < cap && !found; k++)
            begin
                idx = (start + k) % cap;
                found = shadow_written[idx];
            end
            offs = (idx - rd_ptr + cap) % cap;
            offs += cap * $urandom_range(0, (1023 - offs) / cap);
        end
        if (cap == 0 || found)
            send_request(OP_PEEK, 1'b0, CNT_W'($urandom), BYTE_W'($urandom), OFFS_W'(offs));
        else
            send_request(OP_TAKE, 1'b0, CNT_W'($urandom), BYTE_W'($urandom),
                         OFFS_W'($urandom));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (ring_status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        capacity_reg = int'(value);
        wr_ptr = 0;
        rd_ptr = 0;
        reserved = 0;
        awaiting = 0;
        drop_tally = '0;
        capacity_writes++;
    endtask

    task automatic test_basic_records();
        send_request(OP_TAKE, 1'b0, 11'd0, 8'd0, 10'd0);
        send_request(OP_ENQUEUE, 1'b0, 11'd0, 8'hFF, 10'd0);
        send_request(OP_ENQUEUE, 1'b1, 11'd0, 8'd0, 10'd0);
        send_request(OP_ENQUEUE, 1'b1, 11'd2047, 8'd0, 10'd0);
        send_request(OP_ENQUEUE, 1'b1, 11'd3, 8'd0, 10'd0);
        send_request(OP_ENQUEUE, 1'b0, 11'd0, 8'h00, 10'd0);
        send_request(OP_ENQUEUE, 1'b0, 11'd0, 8'hFF, 10'd0);
        send_request(OP_ENQUEUE, 1'b0, 11'd0, 8'hA5, 10'd0);
        send_request(OP_PEEK, 1'b0, 11'd0, 8'd0, 10'd2);
        // record cut short by the next first byte
        send_request(OP_ENQUEUE, 1'b1, 11'd4, 8'd0, 10'd0);
        send_request(OP_ENQUEUE, 1'b0, 11'd0, 8'h5A, 10'd0);
        send_request(OP_ENQUEUE, 1'b1, 11'd2, 8'd0, 10'd0);
        send_request(OP_ENQUEUE, 1'b0, 11'd0, 8'h11, 10'd0);
        send_request(OP_ENQUEUE, 1'b0, 11'd0, 8'h22, 10'd0);
        send_request(OP_CONSUME, 1'b0, 11'd2047, 8'd0, 10'd0);
        send_request(OP_TAKE, 1'b0, 11'd0, 8'd0, 10'd0);
    endtask

    task automatic test_tiny_capacity();
        write_capacity(11'd2);
        send_request(OP_ENQUEUE, 1'b1, 11'd2, 8'd0, 10'd0);
        send_request(OP_ENQUEUE, 1'b0, 11'd0, 8'h3C, 10'd0);
        send_request(OP_ENQUEUE, 1'b0, 11'd0, 8'hC3, 10'd0);
        send_request(OP_ENQUEUE, 1'b1, 11'd1, 8'd0, 10'd0);
        send_request(OP_CONSUME, 1'b0, 11'd1, 8'd0, 10'd0);
        send_request(OP_ENQUEUE, 1'b1, 11'd1, 8'd0, 10'd0);
        send_request(OP_ENQUEUE, 1'b0, 11'd0, 8'h77, 10'd0);
        send_request(OP_PEEK, 1'b0, 11'd0, 8'd0, 10'd1023);
        send_request(OP_CONSUME, 1'b0, 11'd2047, 8'd0, 10'd0);
    endtask

    task automatic test_zero_capacity();
        write_capacity(11'd0);
        send_request(OP_ENQUEUE, 1'b1, 11'd1, 8'd0, 10'd0);
        send_request(OP_ENQUEUE, 1'b0, 11'd0, 8'h81, 10'd0);
        send_request(OP_CONSUME, 1'b0, 11'd5, 8'd0, 10'd0);
        send_request(OP_PEEK, 1'b0, 11'd0, 8'd0, 10'd1023);
        send_request(OP_TAKE, 1'b0, 11'd0, 8'd0, 10'd0);
    endtask

    task automatic test_capacity_above_max();
        write_capacity(11'd2047);
        send_request(OP_ENQUEUE, 1'b1, 11'd1024, 8'd0, 10'd0);
        send_request(OP_ENQUEUE, 1'b1, 11'd1, 8'd0, 10'd0);
        send_request(OP_CONSUME, 1'b0, 11'd1000, 8'd0, 10'd0);
        send_peek();
        send_request(OP_CONSUME, 1'b0, 11'd2047, 8'd0, 10'd0);
        send_request(OP_TAKE, 1'b0, 11'd0, 8'd0, 10'd0);
    endtask

    task automatic random_traffic(int n);
        int start;
        int pick;
        int cap;
        int len;
        int body;
        start = requests_sent;
        while (requests_sent - start < n)
        begin
            cap = eff_capacity();
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                len = ($urandom_range(0, 29) == 0) ? $urandom_range(1, cap + 2)
                                                  : $urandom_range(1, 8);
                body = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
                // long records are cut short to keep the run length down
                if (body > 16)
                    body = $urandom_range(1, 16);
                send_request(OP_ENQUEUE, 1'b1, CNT_W'(len), BYTE_W'($urandom),
                             OFFS_W'($urandom));
                // bytes of a dropped record are sent anyway but at most two
                if (awaiting == 0)
                    body = (body < 2) ? body : 2;
                repeat (body) send_request(OP_ENQUEUE, 1'b0, CNT_W'($urandom),
                                           BYTE_W'($urandom), OFFS_W'($urandom));
            end
            else if (pick < 60)
            begin
                send_request(OP_CONSUME, 1'b0,
                             CNT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                                : $urandom_range(0, 10)),
                             BYTE_W'($urandom), OFFS_W'($urandom));
            end
            else if (pick < 75)
            begin
                send_peek();
            end
            else if (pick < 83)
            begin
                send_request(OP_TAKE, 1'b0, CNT_W'($urandom), BYTE_W'($urandom),
                             OFFS_W'($urandom));
            end
            else if (pick < 93)
            begin
                send_request(OP_ENQUEUE, 1'b0, CNT_W'($urandom), BYTE_W'($urandom),
                             OFFS_W'($urandom));
            end
            else
            begin
                send_request(OP_ENQUEUE, 1'b1,
                             CNT_W'($urandom_range(0, 1) ? 0 : $urandom_range(cap + 1, 2047)),
                             BYTE_W'($urandom), OFFS_W'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        send_gap_pct = 9;
        recv_stall_pct = 55;
        write_capacity(11'd1024);
        random_traffic(60);
        write_capacity(11'd3);
        random_traffic(60);
        send_gap_pct = 55;
        recv_stall_pct = 9;
        write_capacity(11'd2047);
        random_traffic(60);
        write_capacity(11'd1);
        random_traffic(60);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        write_capacity(11'd64);
        random_traffic(60);
        write_capacity(11'd1000);
        random_traffic(60);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_records();
        test_tiny_capacity();
        test_zero_capacity();
        test_capacity_above_max();
        test_random_traffic();
        wait_for_results();
        $display("%0d requests sent, %0d results checked, %0d capacity settings",
                 requests_sent, results_checked, capacity_writes);
        $display("%0d records admitted and %0d dropped, stalls on both sides and none",
                 records_admitted, records_dropped);
        if (failures == 0 && ring_status_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
